[hw/rtl/kdb_pkg.sv]
// Shared types and constants for the key debounce / long press / auto-repeat unit.
// No dependencies; imported by kdb_key_cell and key_debounce_long_press_repeat_unit.
`timescale 1ns / 1ps
`default_nettype none

package kdb_pkg;

  // Number of pin level bits carried by one scan tick.
  localparam int PIN_W         = 2;
  localparam int FILTER_W      = 7;
  localparam int FCOUNT_W      = 8;
  localparam int LONG_W        = 16;
  localparam int REPEAT_W      = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int KIND_W        = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPEED  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [PIN_W-1:0]    RST_ACTIVE_LEVELS = 2'd0;
  localparam logic [FILTER_W-1:0] RST_FILTER_TIME   = 7'd5;
  localparam logic [LONG_W-1:0]   RST_LONG_TIME     = 16'd100;
  localparam logic [REPEAT_W-1:0] RST_REPEAT_SPEED  = 8'd6;

  // Event kinds as they appear on the result channel.
  typedef enum logic [KIND_W-1:0] {
    EV_DOWN = 2'd0,
    EV_UP   = 2'd1,
    EV_LONG = 2'd2
  } kdb_event_t;

  // Timing settings shared by all key cells.
  typedef struct packed {
    logic [FILTER_W-1:0] filter_time;
    logic [LONG_W-1:0]   long_time;
    logic [REPEAT_W-1:0] repeat_speed;
  } kdb_cfg_t;

  // Events one key raises on one tick: a press/release event first, then
  // a long press or repeat event.
  typedef struct packed {
    logic       ev0_vld;
    kdb_event_t ev0_kind;
    logic       ev1_vld;
    kdb_event_t ev1_kind;
  } kdb_key_ev_t;

endpackage : kdb_pkg

`default_nettype wire

[hw/rtl/key_debounce_long_press_repeat_unit.sv]
// A scan tick is accepted into the input register and evaluated from there; its events are
// loaded into the head record, which drives out_tvalid, then go out one per cycle while out_tready is high.
// Throughput: one tick per cycle while ticks raise at most one event each and out_tready is
// high; otherwise the single result port sets the pace at one event per cycle.
// Reset (rst_n low, synchronous) clears all key state and the pipeline and reloads the
// configuration registers with active_levels 0, filter_time 5, long_time 100, repeat_speed 6.
// Top level of the key debounce unit; depends on kdb_pkg and kdb_key_cell.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_long_press_repeat_unit #(
  parameter int KEYS = 2
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Scan tick channel.
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [7:0]                       in_tdata,   // [1:0] pin_levels, rest zero
  input  wire  [0:0]                       in_tuser,   // [0] command
  // Event channel.
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [7:0]                       out_tdata,  // [0] key_index, rest zero
  output logic [1:0]                       out_tuser,  // [1:0] event_kind
  output logic                             out_tlast,
  // Configuration write port.
  input  wire                              cfg_we,
  input  wire  [kdb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [kdb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import kdb_pkg::*;

  // Each key owns two event slots per tick: slot 2k for press/release and
  // slot 2k+1 for long press or repeat. Slots drain lowest first, which
  // gives key order and, within a key, the order the events arise.
  localparam int SLOTS = 2 * KEYS;

  // ---------------------------------------------------------------------
  // Configuration registers. The user must write them only while the unit is idle; the block does not enforce it.
  // ---------------------------------------------------------------------
  logic [PIN_W-1:0] active_levels_r;
  kdb_cfg_t         cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_levels_r    <= RST_ACTIVE_LEVELS;
      cfg_r.filter_time  <= RST_FILTER_TIME;
      cfg_r.long_time    <= RST_LONG_TIME;
      cfg_r.repeat_speed <= RST_REPEAT_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_LEVELS: active_levels_r    <= cfg_wdata[PIN_W-1:0];
        CFG_FILTER_TIME:   cfg_r.filter_time  <= cfg_wdata[FILTER_W-1:0];
        CFG_LONG_TIME:     cfg_r.long_time    <= cfg_wdata[LONG_W-1:0];
        CFG_REPEAT_SPEED:  cfg_r.repeat_speed <= cfg_wdata[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register. A tick waits here until the spare event record is free.
  // ---------------------------------------------------------------------
  logic             in_vld_r;
  logic             in_fast_r;
  logic [PIN_W-1:0] in_pins_r;
  logic             advance;
  logic             pend_vld_r;

  assign advance   = in_vld_r && !pend_vld_r;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_fast_r <= in_tuser[0];
      in_pins_r <= in_tdata[PIN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sole-key detection: a key is down only when it is the one active key.
  // Keys beyond the pin field have no pin level and always count as
  // active.
  // ---------------------------------------------------------------------
  logic [KEYS-1:0] act;
  logic            sole;
  logic [KEYS-1:0] key_down;

  for (genvar k = 0; k < KEYS; k++) begin : g_act
    if (k < PIN_W) begin : g_pin
      assign act[k] = (in_pins_r[k] == active_levels_r[k]);
    end else begin : g_nopin
      assign act[k] = 1'b1;
    end
  end

  assign sole     = (act != '0) && ((act & (act - 1'b1)) == '0);
  assign key_down = sole ? act : '0;

  // ---------------------------------------------------------------------
  // Key cells and the event record they produce for this tick.
  // ---------------------------------------------------------------------
  kdb_key_ev_t      key_ev [KEYS];
  logic [SLOTS-1:0] new_mask;
  kdb_event_t       new_kind [SLOTS];
  logic             new_rec_vld;

  for (genvar k = 0; k < KEYS; k++) begin : g_key
    kdb_key_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick_en (advance),
      .fast    (in_fast_r),
      .down    (key_down[k]),
      .cfg     (cfg_r),
      .ev      (key_ev[k])
    );
    assign new_mask[2*k]   = key_ev[k].ev0_vld;
    assign new_mask[2*k+1] = key_ev[k].ev1_vld;
    assign new_kind[2*k]   = key_ev[k].ev0_kind;
    assign new_kind[2*k+1] = key_ev[k].ev1_kind;
  end

  // A tick with no event leaves no record, so it produces no result.
  assign new_rec_vld = advance && (new_mask != '0);

  // ---------------------------------------------------------------------
  // Event records: the head record drives the result channel, the spare
  // record lets the next tick be evaluated while the head still drains.
  // ---------------------------------------------------------------------
  logic             head_vld_r;
  logic [SLOTS-1:0] head_mask_r;
  kdb_event_t       head_kind_r [SLOTS];
  logic [SLOTS-1:0] pend_mask_r;
  kdb_event_t       pend_kind_r [SLOTS];

  logic             sel_key;
  kdb_event_t       sel_kind;
  logic [SLOTS-1:0] head_rest;
  logic             out_fire;
  logic             head_done;
  logic             head_avail;

  // Lowest pending slot of the head record.
  always_comb begin
    sel_key  = 1'b0;
    sel_kind = EV_DOWN;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (head_mask_r[i]) begin
        sel_key  = i[1];
        sel_kind = head_kind_r[i];
      end
    end
  end

  assign head_rest  = head_mask_r & (head_mask_r - 1'b1);
  assign out_fire   = out_tvalid && out_tready;
  assign head_done  = out_fire && (head_rest == '0);
  assign head_avail = !head_vld_r || head_done;

  assign out_tvalid = head_vld_r;
  assign out_tdata  = {7'd0, sel_key};
  assign out_tuser  = sel_kind;
  assign out_tlast  = (head_rest == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
    end else if (head_avail) begin
      if (pend_vld_r) begin
        head_vld_r <= 1'b1;
        pend_vld_r <= 1'b0;
      end else begin
        head_vld_r <= new_rec_vld;
      end
    end else if (new_rec_vld) begin
      pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_avail) begin
      if (pend_vld_r) begin
        head_mask_r <= pend_mask_r;
        head_kind_r <= pend_kind_r;
      end else begin
        head_mask_r <= new_mask;
        head_kind_r <= new_kind;
      end
    end else begin
      if (out_fire) begin
        head_mask_r <= head_rest;
      end
      if (new_rec_vld) begin
        pend_mask_r <= new_mask;
        pend_kind_r <= new_kind;
      end
    end
  end

`ifndef SYNTHESIS
  // A record on the result channel always has at least one event left.
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld_r |-> (head_mask_r != '0))
    else $error("head event record is valid but empty");

  // The spare record is only occupied behind a busy head record.
  a_pend_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> head_vld_r)
    else $error("spare event record valid while head is empty");

  // When the head finishes with a spare record waiting, the spare moves up intact.
  a_pend_promote: assert property (@(posedge clk) disable iff (!rst_n)
    (head_avail && pend_vld_r) |=> (head_vld_r && head_mask_r == $past(pend_mask_r)))
    else $error("spare event record not promoted to head");

  // The input side only stalls while a tick waits on a full spare record.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && pend_vld_r))
    else $error("scan tick stalled without a full spare record");
`endif

endmodule : key_debounce_long_press_repeat_unit

`default_nettype wire

[hw/rtl/kdb_key_cell.sv]
// State and next-state logic of one key: filter counter, pressed flag,
// hold counter and repeat counter. Depends on kdb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kdb_key_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  tick_en,
  input  wire                  fast,
  input  wire                  down,
  input  wire kdb_pkg::kdb_cfg_t cfg,
  output kdb_pkg::kdb_key_ev_t ev
);
  import kdb_pkg::*;

  logic [FCOUNT_W-1:0] fcount_r, fcount_nxt;
  logic                pressed_r, pressed_nxt;
  logic [LONG_W-1:0]   hold_r, hold_nxt;
  logic [REPEAT_W-1:0] rep_r, rep_nxt;

  logic                held_go;
  logic                rel_go;
  logic [FCOUNT_W-1:0] f_ext;
  logic [FCOUNT_W-1:0] f_twice;
  logic [LONG_W-1:0]   hold_inc;
  logic [REPEAT_W:0]   rep_inc;

  always_comb begin
    f_ext       = {1'b0, cfg.filter_time};
    f_twice     = {cfg.filter_time, 1'b0};
    hold_inc    = hold_r + 16'd1;
    rep_inc     = {1'b0, rep_r} + 9'd1;
    fcount_nxt  = fcount_r;
    pressed_nxt = pressed_r;
    hold_nxt    = hold_r;
    rep_nxt     = rep_r;
    held_go     = 1'b0;
    rel_go      = 1'b0;
    ev          = '{ev0_vld: 1'b0, ev0_kind: EV_DOWN, ev1_vld: 1'b0, ev1_kind: EV_DOWN};

    if (fast) begin
      held_go = down;
      rel_go  = !down;
    end else if (down) begin
      if (fcount_r < f_ext) begin
        fcount_nxt = f_ext;
      end else if (fcount_r < f_twice) begin
        fcount_nxt = fcount_r + 8'd1;
      end else begin
        held_go = 1'b1;
      end
    end else begin
      if (fcount_r > f_ext) begin
        fcount_nxt = f_ext;
      end else if (fcount_r != '0) begin
        fcount_nxt = fcount_r - 8'd1;
      end else begin
        rel_go = 1'b1;
      end
    end

    // Any tick on which the key is not down restarts hold and repeat timing.
    if (!down) begin
      hold_nxt = '0;
      rep_nxt  = '0;
    end

    if (held_go) begin
      if (!pressed_r) begin
        pressed_nxt = 1'b1;
        ev.ev0_vld  = 1'b1;
        ev.ev0_kind = EV_DOWN;
      end
      if (cfg.long_time != '0) begin
        if (hold_r < cfg.long_time) begin
          hold_nxt = hold_inc;
          if (hold_inc == cfg.long_time) begin
            ev.ev1_vld  = 1'b1;
            ev.ev1_kind = EV_LONG;
          end
        end else if (cfg.repeat_speed != '0) begin
          if (rep_inc >= {1'b0, cfg.repeat_speed}) begin
            rep_nxt     = '0;
            ev.ev1_vld  = 1'b1;
            ev.ev1_kind = EV_DOWN;
          end else begin
            rep_nxt = rep_inc[REPEAT_W-1:0];
          end
        end
      end
    end

    if (rel_go && pressed_r) begin
      pressed_nxt = 1'b0;
      ev.ev0_vld  = 1'b1;
      ev.ev0_kind = EV_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r  <= '0;
      pressed_r <= 1'b0;
      hold_r    <= '0;
      rep_r     <= '0;
    end else if (tick_en) begin
      fcount_r  <= fcount_nxt;
      pressed_r <= pressed_nxt;
      hold_r    <= hold_nxt;
      rep_r     <= rep_nxt;
    end
  end

endmodule : kdb_key_cell

`default_nettype wire
